@@ src/mbk_pkg.sv @@
package mbk_pkg;

    localparam int TEXT_LEN  = 64;
    localparam int POS_W     = $clog2(TEXT_LEN);
    localparam int TIME_W    = 19;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [TIME_W-1:0] ELAPSED_MAX = {TIME_W{1'b1}};

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_WRITE = 2'd3
    } opcode_t;

    localparam logic [CFG_IDX_W-1:0] REG_UNIT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WARMUP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CARRIER = 3'd4;

    localparam logic [7:0] CHAR_NUL        = 8'h00;
    localparam logic [7:0] CHAR_SPACE      = 8'h20;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

    typedef struct packed {
        logic [CFG_W-1:0] unit_ms;
        logic [CFG_W-1:0] warmup_ms;
        logic [CFG_W-1:0] end_ms;
        logic [CFG_W-1:0] repeat_ms;
        logic [CFG_W-1:0] carrier_ms;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] opcode;
        logic [5:0] text_index;
        logic [7:0] text_char;
    } cmd_t;

    typedef struct packed {
        logic             en;
        logic [POS_W-1:0] addr;
        logic [7:0]       data;
    } store_wr_t;

    typedef struct packed {
        logic       tone_on;
        logic       tx_active;
        logic [3:0] phase;
        logic [5:0] text_position;
    } status_t;

    typedef struct packed {
        logic       known;
        logic [2:0] len;
        logic [7:0] pattern;
    } morse_code_t;

    // Code ROM: dah is a one, first element ends up in the MSB of pattern.
    function automatic morse_code_t code_lookup(input logic [7:0] ch);
        morse_code_t c;
        logic [7:0]  raw;
        c.known = 1'b1;
        c.len   = 3'd0;
        raw     = 8'h00;
        case (ch)
            8'h41: begin c.len = 3'd2; raw = 8'h01; end // A
            8'h42: begin c.len = 3'd4; raw = 8'h08; end
            8'h43: begin c.len = 3'd4; raw = 8'h0A; end
            8'h44: begin c.len = 3'd3; raw = 8'h04; end
            8'h45: begin c.len = 3'd1; raw = 8'h00; end
            8'h46: begin c.len = 3'd4; raw = 8'h02; end
            8'h47: begin c.len = 3'd3; raw = 8'h06; end
            8'h48: begin c.len = 3'd4; raw = 8'h00; end
            8'h49: begin c.len = 3'd2; raw = 8'h00; end
            8'h4A: begin c.len = 3'd4; raw = 8'h07; end
            8'h4B: begin c.len = 3'd3; raw = 8'h05; end
            8'h4C: begin c.len = 3'd4; raw = 8'h04; end
            8'h4D: begin c.len = 3'd2; raw = 8'h03; end
            8'h4E: begin c.len = 3'd2; raw = 8'h02; end
            8'h4F: begin c.len = 3'd3; raw = 8'h07; end
            8'h50: begin c.len = 3'd4; raw = 8'h06; end
            8'h51: begin c.len = 3'd4; raw = 8'h0D; end
            8'h52: begin c.len = 3'd3; raw = 8'h02; end
            8'h53: begin c.len = 3'd3; raw = 8'h00; end
            8'h54: begin c.len = 3'd1; raw = 8'h01; end
            8'h55: begin c.len = 3'd3; raw = 8'h01; end
            8'h56: begin c.len = 3'd4; raw = 8'h01; end
            8'h57: begin c.len = 3'd3; raw = 8'h03; end
            8'h58: begin c.len = 3'd4; raw = 8'h09; end
            8'h59: begin c.len = 3'd4; raw = 8'h0B; end
            8'h5A: begin c.len = 3'd4; raw = 8'h0C; end // Z
            8'h30: begin c.len = 3'd5; raw = 8'h1F; end // 0
            8'h31: begin c.len = 3'd5; raw = 8'h0F; end
            8'h32: begin c.len = 3'd5; raw = 8'h07; end
            8'h33: begin c.len = 3'd5; raw = 8'h03; end
            8'h34: begin c.len = 3'd5; raw = 8'h01; end
            8'h35: begin c.len = 3'd5; raw = 8'h00; end
            8'h36: begin c.len = 3'd5; raw = 8'h10; end
            8'h37: begin c.len = 3'd5; raw = 8'h18; end
            8'h38: begin c.len = 3'd5; raw = 8'h1C; end
            8'h39: begin c.len = 3'd5; raw = 8'h1E; end // 9
            8'h2F: begin c.len = 3'd5; raw = 8'h12; end // slash
            default: c.known = 1'b0;
        endcase
        c.pattern = raw << (4'd8 - {1'b0, c.len});
        return c;
    endfunction

endpackage

@@ src/mbk_if.sv @@
interface mbk_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [5:0] text_index;
    logic [7:0] text_char;

    modport source (output valid, output opcode, output text_index, output text_char,
                    input ready);
    modport sink   (input valid, input opcode, input text_index, input text_char,
                    output ready);
endinterface

interface mbk_status_if;
    logic       valid;
    logic       ready;
    logic       tone_on;
    logic       tx_active;
    logic [3:0] phase;
    logic [5:0] text_position;

    modport source (output valid, output tone_on, output tx_active, output phase,
                    output text_position, input ready);
    modport sink   (input valid, input tone_on, input tx_active, input phase,
                    input text_position, output ready);
endinterface

interface mbk_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mbk_pkg::CFG_IDX_W-1:0]  index;
    logic [mbk_pkg::CFG_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/mbk_text_store.sv @@
module mbk_text_store (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mbk_pkg::store_wr_t           wr,
    input  logic [mbk_pkg::POS_W-1:0]    rd_addr,
    output logic [7:0]                   rd_char
);

    logic [7:0]                   mem [mbk_pkg::TEXT_LEN];
    logic [mbk_pkg::TEXT_LEN-1:0] valid_reg;
    logic [7:0]                   rd_char_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Entries never written read as terminator; forward a write to the same address.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            rd_char_reg <= mbk_pkg::CHAR_NUL;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (wr.en && (wr.addr == rd_addr))
            begin
                rd_char_reg <= wr.data;
            end
            else if (valid_reg[rd_addr])
            begin
                rd_char_reg <= mem[rd_addr];
            end
            else
            begin
                rd_char_reg <= mbk_pkg::CHAR_NUL;
            end
        end
    end

    assign rd_char = rd_char_reg;

endmodule

@@ src/mbk_sequencer.sv @@
module mbk_sequencer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mbk_pkg::cmd_t                cmd,
    input  logic                         fire,
    input  mbk_pkg::cfg_t                cfg,
    input  logic [7:0]                   rd_char,
    output mbk_pkg::store_wr_t           wr,
    output logic [mbk_pkg::POS_W-1:0]    rd_addr,
    output mbk_pkg::status_t             status_next
);

    typedef enum logic [3:0] {
        PH_STOP   = 4'd0,
        PH_WARM   = 4'd1,
        PH_DIT    = 4'd2,
        PH_DAH    = 4'd3,
        PH_EGAP   = 4'd4,
        PH_LGAP   = 4'd5,
        PH_SPACE  = 4'd6,
        PH_CARR   = 4'd7,
        PH_END    = 4'd8,
        PH_REPEAT = 4'd9
    } phase_t;

    localparam logic [mbk_pkg::POS_W-1:0] LAST_POS = mbk_pkg::POS_W'(mbk_pkg::TEXT_LEN - 1);

    phase_t                        phase_reg,    phase_next;
    logic [mbk_pkg::TIME_W-1:0]    elapsed_reg,  elapsed_next;
    logic [mbk_pkg::TIME_W-1:0]    timeout_reg,  timeout_next;
    logic [mbk_pkg::POS_W-1:0]     read_pos_reg, read_pos_next;
    logic [7:0]                    pattern_reg,  pattern_next;
    logic [2:0]                    elements_reg, elements_next;

    logic [mbk_pkg::TIME_W-1:0]    unit1, unit3, unit7, elapsed_inc;
    logic [7:0]                    char_in;
    logic [mbk_pkg::POS_W-1:0]     pos_base;
    mbk_pkg::morse_code_t          code;

    phase_t                        char_phase, elem_phase;
    logic [mbk_pkg::POS_W-1:0]     char_pos;
    logic [7:0]                    char_pattern, elem_pattern;
    logic [2:0]                    char_elems,   elem_elems;

    function automatic logic [mbk_pkg::TIME_W-1:0] timeout_of(input phase_t ph,
                                                             input mbk_pkg::cfg_t c,
                                                             input logic [mbk_pkg::TIME_W-1:0] u1,
                                                             input logic [mbk_pkg::TIME_W-1:0] u3,
                                                             input logic [mbk_pkg::TIME_W-1:0] u7);
        logic [mbk_pkg::TIME_W-1:0] t;
        unique case (ph)
            PH_WARM:          t = mbk_pkg::TIME_W'(c.warmup_ms);
            PH_DAH, PH_LGAP:  t = u3;
            PH_SPACE:         t = u7;
            PH_CARR:          t = mbk_pkg::TIME_W'(c.carrier_ms);
            PH_END:           t = mbk_pkg::TIME_W'(c.end_ms);
            PH_REPEAT:        t = mbk_pkg::TIME_W'(c.repeat_ms);
            default:          t = u1;
        endcase
        return t;
    endfunction

    assign unit1 = mbk_pkg::TIME_W'(cfg.unit_ms);
    assign unit3 = mbk_pkg::TIME_W'({cfg.unit_ms, 1'b0}) + unit1;
    assign unit7 = mbk_pkg::TIME_W'({cfg.unit_ms, 3'b000}) - unit1;

    assign elapsed_inc = (elapsed_reg == mbk_pkg::ELAPSED_MAX) ? elapsed_reg
                                                              : elapsed_reg + 1'b1;

    // Warm-up restarts the text at the first entry; the last entry is a terminator.
    assign pos_base = (phase_reg == PH_WARM) ? '0 : read_pos_reg;
    assign char_in  = (pos_base == LAST_POS) ? mbk_pkg::CHAR_NUL : rd_char;
    assign code     = mbk_pkg::code_lookup(char_in);

    always_comb
    begin
        char_pos     = pos_base + 1'b1;
        char_pattern = pattern_reg;
        char_elems   = elements_reg;
        if (char_in == mbk_pkg::CHAR_NUL)
        begin
            char_pos   = '0;
            char_phase = PH_END;
        end
        else if (char_in == mbk_pkg::CHAR_SPACE)
        begin
            char_phase = PH_SPACE;
        end
        else if (char_in == mbk_pkg::CHAR_UNDERSCORE)
        begin
            char_phase = PH_CARR;
        end
        else if (!code.known)
        begin
            char_phase = PH_SPACE;
        end
        else
        begin
            // Take the first element right away.
            char_phase   = code.pattern[7] ? PH_DAH : PH_DIT;
            char_pattern = {code.pattern[6:0], 1'b0};
            char_elems   = code.len - 1'b1;
        end
    end

    always_comb
    begin
        elem_pattern = pattern_reg;
        elem_elems   = elements_reg;
        if (elements_reg == 3'd0)
        begin
            elem_phase = PH_LGAP;
        end
        else
        begin
            elem_phase   = pattern_reg[7] ? PH_DAH : PH_DIT;
            elem_pattern = {pattern_reg[6:0], 1'b0};
            elem_elems   = elements_reg - 1'b1;
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        elapsed_next  = elapsed_reg;
        timeout_next  = timeout_reg;
        read_pos_next = read_pos_reg;
        pattern_next  = pattern_reg;
        elements_next = elements_reg;
        if (fire)
        begin
            unique case (mbk_pkg::opcode_t'(cmd.opcode))
                mbk_pkg::OP_TICK:
                begin
                    if (phase_reg != PH_STOP)
                    begin
                        if (elapsed_inc > timeout_reg)
                        begin
                            elapsed_next = '0;
                            unique case (phase_reg)
                                PH_WARM, PH_LGAP, PH_SPACE, PH_CARR:
                                begin
                                    phase_next    = char_phase;
                                    read_pos_next = char_pos;
                                    pattern_next  = char_pattern;
                                    elements_next = char_elems;
                                end
                                PH_DIT, PH_DAH: phase_next = PH_EGAP;
                                PH_EGAP:
                                begin
                                    phase_next    = elem_phase;
                                    pattern_next  = elem_pattern;
                                    elements_next = elem_elems;
                                end
                                PH_END:  phase_next = PH_REPEAT;
                                default: phase_next = PH_WARM;
                            endcase
                            timeout_next = timeout_of(phase_next, cfg, unit1, unit3, unit7);
                        end
                        else
                        begin
                            elapsed_next = elapsed_inc;
                        end
                    end
                end
                mbk_pkg::OP_START:
                begin
                    phase_next   = PH_WARM;
                    timeout_next = mbk_pkg::TIME_W'(cfg.warmup_ms);
                    elapsed_next = '0;
                end
                mbk_pkg::OP_STOP:
                begin
                    phase_next = PH_STOP;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_STOP;
            elapsed_reg  <= '0;
            timeout_reg  <= '0;
            read_pos_reg <= '0;
            pattern_reg  <= '0;
            elements_reg <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            elapsed_reg  <= elapsed_next;
            timeout_reg  <= timeout_next;
            read_pos_reg <= read_pos_next;
            pattern_reg  <= pattern_next;
            elements_reg <= elements_next;
        end
    end

    assign wr.en   = fire && (mbk_pkg::opcode_t'(cmd.opcode) == mbk_pkg::OP_WRITE)
                     && (32'(cmd.text_index) < 32'(mbk_pkg::TEXT_LEN));
    assign wr.addr = mbk_pkg::POS_W'(cmd.text_index);
    assign wr.data = cmd.text_char;

    // Prefetch the character the next advance will need.
    assign rd_addr = (phase_next == PH_WARM) ? '0 : read_pos_next;

    assign status_next.tone_on       = (phase_next == PH_DIT) || (phase_next == PH_DAH)
                                       || (phase_next == PH_CARR);
    assign status_next.tx_active     = (phase_next != PH_STOP) && (phase_next != PH_REPEAT);
    assign status_next.phase         = phase_next;
    assign status_next.text_position = 6'(read_pos_next);

    a_elapsed_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        elapsed_reg <= timeout_reg)
        else $error("elapsed counter passed the phase timeout");

    a_lgap_no_elements: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LGAP) |-> (elements_reg == 3'd0))
        else $error("letter gap entered with elements left");

    a_end_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_END) |-> (read_pos_reg == '0))
        else $error("end of text without rewinding the read position");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(phase_reg) && $stable(elapsed_reg) && $stable(read_pos_reg))
        else $error("keyer state moved without a transaction");

endmodule

@@ src/morse_beacon_keyer_core.sv @@
// Channel  Modport  Fields                                       Transaction
// cmd      sink     opcode, text_index, text_char                valid & ready
// status   source   tone_on, tx_active, phase, text_position     valid & ready
// cfg      sink     index, data                                  valid & ready
//
// One command per clock sustained while status.ready holds: the command is registered,
// processed in one pass through the sequencer, and its status is registered.
// Reset clears the timing registers, the phase and the text store valid bits;
// the store needs no clearing pass.
// A stalled status holds the pipeline; cmd.ready drops only while both stages
// are full and status.ready is low. cfg is always ready.
module morse_beacon_keyer_core (
    input  logic           clk,
    input  logic           rst_n,
    mbk_cmd_if.sink        cmd,
    mbk_status_if.source   status,
    mbk_cfg_if.sink        cfg
);

    mbk_pkg::cmd_t              in_reg;
    mbk_pkg::cfg_t              cfg_reg;
    mbk_pkg::status_t           out_reg;
    logic                       out_valid_reg;

    logic                       out_free;
    logic                       fire;
    mbk_pkg::status_t           status_next;
    mbk_pkg::store_wr_t         wr;
    logic [mbk_pkg::POS_W-1:0]  rd_addr;
    logic [7:0]                 rd_char;

    // Process the held command when the status register can take its result.
    assign out_free  = !out_valid_reg || status.ready;
    assign fire      = in_reg.valid && out_free;
    assign cmd.ready = !in_reg.valid || out_free;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_reg <= '0;
        end
        else if (cmd.ready)
        begin
            in_reg.valid      <= cmd.valid;
            in_reg.opcode     <= cmd.opcode;
            in_reg.text_index <= cmd.text_index;
            in_reg.text_char  <= cmd.text_char;
        end
    end

    // Register writes; an index past the list drops the write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.unit_ms    <= 16'd150;
            cfg_reg.warmup_ms  <= 16'd3000;
            cfg_reg.end_ms     <= 16'd3000;
            cfg_reg.repeat_ms  <= 16'd30000;
            cfg_reg.carrier_ms <= 16'd4000;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                mbk_pkg::REG_UNIT:    cfg_reg.unit_ms    <= cfg.data;
                mbk_pkg::REG_WARMUP:  cfg_reg.warmup_ms  <= cfg.data;
                mbk_pkg::REG_END:     cfg_reg.end_ms     <= cfg.data;
                mbk_pkg::REG_REPEAT:  cfg_reg.repeat_ms  <= cfg.data;
                mbk_pkg::REG_CARRIER: cfg_reg.carrier_ms <= cfg.data;
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

    mbk_sequencer u_sequencer (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (in_reg),
        .fire        (fire),
        .cfg         (cfg_reg),
        .rd_char     (rd_char),
        .wr          (wr),
        .rd_addr     (rd_addr),
        .status_next (status_next)
    );

    mbk_text_store u_text_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_char (rd_char)
    );

    // Hold the status until the sink takes it; load a new one on every processed command.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (status.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg <= status_next;
        end
    end

    assign status.valid         = out_valid_reg;
    assign status.tone_on       = out_reg.tone_on;
    assign status.tx_active     = out_reg.tx_active;
    assign status.phase         = out_reg.phase;
    assign status.text_position = out_reg.text_position;

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

// Standalone check of the Morse beacon keyer: every command transaction is run
// through a local model of the keyer, and each status transaction is compared
// with the oldest prediction still waiting.
module testbench;

    // Keyer phases as the status channel reports them.
    typedef enum logic [3:0] {
        KP_STOPPED      = 4'd0,
        KP_WARMUP       = 4'd1,
        KP_DIT          = 4'd2,
        KP_DAH          = 4'd3,
        KP_ELEM_GAP     = 4'd4,
        KP_LETTER_GAP   = 4'd5,
        KP_WORD_SPACE   = 4'd6,
        KP_CARRIER      = 4'd7,
        KP_END_PAUSE    = 4'd8,
        KP_REPEAT_PAUSE = 4'd9
    } keyer_phase_t;

    localparam logic [15:0] MS_MAX = 16'hFFFF;

    logic clk = 1'b0;
    logic rst_n;

    mbk_cmd_if    cmd_if ();
    mbk_status_if status_if ();
    mbk_cfg_if    cfg_if ();

    morse_beacon_keyer_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_if),
        .status (status_if),
        .cfg    (cfg_if)
    );

    always #5 clk = ~clk;

    // Local copy of the keyer: timing registers, text store and sequencer state.
    mbk_pkg::cfg_t timing;
    logic [7:0]    text_mem [mbk_pkg::TEXT_LEN];
    keyer_phase_t  cur_phase;
    int unsigned   elapsed;
    int unsigned   phase_limit;
    int unsigned   read_pos;
    logic [7:0]    pattern_sr;
    int unsigned   elems_left;

    mbk_pkg::status_t expected_status_q [$];
    int      mismatches;
    int      cmds_sent;
    bit      quiet;       // no gaps and no stalls while set
    int      ready_hold;

    function automatic void keyer_reset();
        timing.unit_ms    = 16'd150;
        timing.warmup_ms  = 16'd3000;
        timing.end_ms     = 16'd3000;
        timing.repeat_ms  = 16'd30000;
        timing.carrier_ms = 16'd4000;
        foreach (text_mem[i]) text_mem[i] = mbk_pkg::CHAR_NUL;
        cur_phase   = KP_STOPPED;
        elapsed     = 0;
        phase_limit = 0;
        read_pos    = 0;
        pattern_sr  = 8'h00;
        elems_left  = 0;
    endfunction

    // Dots and dashes of each character the keyer knows; empty when unknown.
    function automatic string morse_of(input logic [7:0] c);
        string m;
        case (c)
            "A": m = ".-";    "B": m = "-...";  "C": m = "-.-.";  "D": m = "-..";
            "E": m = ".";     "F": m = "..-.";  "G": m = "--.";   "H": m = "....";
            "I": m = "..";    "J": m = ".---";  "K": m = "-.-";   "L": m = ".-..";
            "M": m = "--";    "N": m = "-.";    "O": m = "---";   "P": m = ".--.";
            "Q": m = "--.-";  "R": m = ".-.";   "S": m = "...";   "T": m = "-";
            "U": m = "..-";   "V": m = "...-";  "W": m = ".--";   "X": m = "-..-";
            "Y": m = "-.--";  "Z": m = "--..";
            "0": m = "-----"; "1": m = ".----"; "2": m = "..---"; "3": m = "...--";
            "4": m = "....-"; "5": m = "....."; "6": m = "-...."; "7": m = "--...";
            "8": m = "---.."; "9": m = "----.";
            "/": m = "-..-.";
            default: m = "";
        endcase
        return m;
    endfunction

    function automatic int unsigned timeout_of(input keyer_phase_t p);
        case (p)
            KP_WARMUP:              return timing.warmup_ms;
            KP_DAH, KP_LETTER_GAP:  return 3 * timing.unit_ms;
            KP_WORD_SPACE:          return 7 * timing.unit_ms;
            KP_CARRIER:             return timing.carrier_ms;
            KP_END_PAUSE:           return timing.end_ms;
            KP_REPEAT_PAUSE:        return timing.repeat_ms;
            default:                return timing.unit_ms;
        endcase
    endfunction

    function automatic keyer_phase_t pick_element();
        keyer_phase_t p;
        if (elems_left == 0)
            return KP_LETTER_GAP;
        p = pattern_sr[7] ? KP_DAH : KP_DIT;
        pattern_sr = pattern_sr << 1;
        elems_left--;
        return p;
    endfunction

    // The last store entry always reads as a terminator.
    function automatic keyer_phase_t fetch_char();
        logic [7:0] c;
        string      m;
        c = mbk_pkg::CHAR_NUL;
        if (read_pos < mbk_pkg::TEXT_LEN - 1)
            c = text_mem[read_pos];
        read_pos++;
        if (c == mbk_pkg::CHAR_NUL)
        begin
            read_pos = 0;
            return KP_END_PAUSE;
        end
        if (c == mbk_pkg::CHAR_SPACE)
            return KP_WORD_SPACE;
        if (c == mbk_pkg::CHAR_UNDERSCORE)
            return KP_CARRIER;
        m = morse_of(c);
        if (m.len() == 0)
            return KP_WORD_SPACE;
        pattern_sr = 8'h00;
        for (int i = 0; i < m.len(); i++)
            if (m[i] == "-")
                pattern_sr[7 - i] = 1'b1;
        elems_left = m.len();
        return pick_element();
    endfunction

    function automatic void next_phase();
        keyer_phase_t nx;
        case (cur_phase)
            KP_WARMUP:
            begin
                read_pos = 0;
                nx = fetch_char();
            end
            KP_DIT, KP_DAH:                          nx = KP_ELEM_GAP;
            KP_ELEM_GAP:                             nx = pick_element();
            KP_LETTER_GAP, KP_WORD_SPACE, KP_CARRIER: nx = fetch_char();
            KP_END_PAUSE:                            nx = KP_REPEAT_PAUSE;
            default:                                 nx = KP_WARMUP;
        endcase
        phase_limit = timeout_of(nx);
        cur_phase   = nx;
    endfunction

    function automatic mbk_pkg::status_t keyer_step(input logic [1:0] op,
                                                    input logic [5:0] idx,
                                                    input logic [7:0] ch);
        mbk_pkg::status_t s;
        case (op)
            mbk_pkg::OP_TICK:
                if (cur_phase != KP_STOPPED)
                begin
                    if (elapsed < mbk_pkg::ELAPSED_MAX)
                        elapsed++;
                    if (elapsed > phase_limit)
                    begin
                        elapsed = 0;
                        next_phase();
                    end
                end
            mbk_pkg::OP_START:
            begin
                cur_phase   = KP_WARMUP;
                phase_limit = timeout_of(KP_WARMUP);
                elapsed     = 0;
            end
            mbk_pkg::OP_STOP:  cur_phase = KP_STOPPED;
            default:           text_mem[idx] = ch;
        endcase
        s.tone_on       = (cur_phase inside {KP_DIT, KP_DAH, KP_CARRIER});
        s.tx_active     = (cur_phase != KP_STOPPED && cur_phase != KP_REPEAT_PAUSE);
        s.phase         = cur_phase;
        s.text_position = read_pos[5:0];
        return s;
    endfunction

    task automatic report_mismatch(input string what, input mbk_pkg::status_t want,
                                   input mbk_pkg::status_t got);
        string want_s;
        string got_s;
        mismatches++;
        if (mismatches <= 10)
        begin
            want_s = $sformatf("tone=%0d active=%0d phase=%0d pos=%0d", want.tone_on,
                               want.tx_active, want.phase, want.text_position);
            got_s  = $sformatf("tone=%0d active=%0d phase=%0d pos=%0d", got.tone_on,
                               got.tx_active, got.phase, got.text_position);
            $display("%0t %s: expected %s, got %s", $realtime, what, want_s, got_s);
        end
    endtask

    // Predict on every command transaction and check every status transaction.
    // Register writes land in the local timing copy at their own transaction.
    always @(posedge clk)
    begin : scoreboard
        mbk_pkg::status_t want;
        mbk_pkg::status_t got;
        if (rst_n)
        begin
            if (cfg_if.valid && cfg_if.ready)
                case (cfg_if.index)
                    mbk_pkg::REG_UNIT:    timing.unit_ms    = cfg_if.data;
                    mbk_pkg::REG_WARMUP:  timing.warmup_ms  = cfg_if.data;
                    mbk_pkg::REG_END:     timing.end_ms     = cfg_if.data;
                    mbk_pkg::REG_REPEAT:  timing.repeat_ms  = cfg_if.data;
                    mbk_pkg::REG_CARRIER: timing.carrier_ms = cfg_if.data;
                    default: ;
                endcase
            if (cmd_if.valid && cmd_if.ready)
                expected_status_q.push_back(keyer_step(cmd_if.opcode, cmd_if.text_index,
                                                       cmd_if.text_char));
            if (status_if.valid && status_if.ready)
            begin
                got.tone_on       = status_if.tone_on;
                got.tx_active     = status_if.tx_active;
                got.phase         = status_if.phase;
                got.text_position = status_if.text_position;
                if (expected_status_q.size() == 0)
                    report_mismatch("status with no command pending", '0, got);
                else
                begin
                    want = expected_status_q.pop_front();
                    if (got.tone_on !== want.tone_on || got.tx_active !== want.tx_active
                        || got.phase !== want.phase
                        || got.text_position !== want.text_position)
                        report_mismatch("status mismatch", want, got);
                end
            end
        end
    end

    // Status back-pressure: random stall bursts, random ready runs, none when quiet.
    initial
    begin
        status_if.ready = 1'b0;
        ready_hold      = 0;
        forever
        begin
            @(posedge clk);
            if (quiet)
                status_if.ready <= 1'b1;
            else if (ready_hold > 0)
                ready_hold--;
            else if ($urandom_range(0, 3) == 0)
            begin
                status_if.ready <= 1'b0;
                ready_hold = $urandom_range(1, 17) - 1;
            end
            else
            begin
                status_if.ready <= 1'b1;
                ready_hold = $urandom_range(1, 40) - 1;
            end
        end
    end

    // Send one command; hold valid across back-to-back transactions, drop it only
    // for a sender gap.
    task automatic send_cmd(input mbk_pkg::opcode_t op, input logic [5:0] idx,
                            input logic [7:0] ch);
        int gap;
        gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 17) : 0;
        if (gap != 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.opcode     <= op;
        cmd_if.text_index <= idx;
        cmd_if.text_char  <= ch;
        do @(posedge clk); while (!cmd_if.ready);
        cmds_sent++;
    endtask

    task automatic send_tick();
        send_cmd(mbk_pkg::OP_TICK, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_tick();
    endtask

    // Drop valid and hold until every status has come back, plus pipeline slack.
    // Step one edge first so the last accepted command has its prediction queued.
    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_status_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [mbk_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] v);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= v;
        do @(posedge clk); while (!cfg_if.ready);
    endtask

    // Write the timing registers selected by mask (bit n is register n), then
    // optionally one write to an index past the register list.
    task automatic set_timing(input logic [15:0] unit_v, warm_v, end_v, rep_v, carr_v,
                              input logic [4:0] mask, input bit poke_unused);
        if (mask[0]) write_reg(mbk_pkg::REG_UNIT, unit_v);
        if (mask[1]) write_reg(mbk_pkg::REG_WARMUP, warm_v);
        if (mask[2]) write_reg(mbk_pkg::REG_END, end_v);
        if (mask[3]) write_reg(mbk_pkg::REG_REPEAT, rep_v);
        if (mask[4]) write_reg(mbk_pkg::REG_CARRIER, carr_v);
        if (poke_unused)
            write_reg(mbk_pkg::REG_CARRIER + 3'($urandom_range(1, 3)),
                      16'($urandom_range(0, 65535)));
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_text_char();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 8'("A" + $urandom_range(0, 25));
            4, 5:       return 8'("0" + $urandom_range(0, 9));
            6:          return "/";
            7:          return mbk_pkg::CHAR_SPACE;
            8:          return mbk_pkg::CHAR_UNDERSCORE;
            default:    return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Ticks while stopped, restart during warm-up, stop, default timing.
    task automatic test_stopped_defaults();
        send_tick();
        send_tick();
        send_cmd(mbk_pkg::OP_WRITE, 6'd63, "K");
        send_cmd(mbk_pkg::OP_WRITE, 6'd0, "E");
        send_cmd(mbk_pkg::OP_STOP, 6'd0, 8'd0);
        send_cmd(mbk_pkg::OP_START, 6'd63, 8'hFF);
        send_ticks(3);
        send_cmd(mbk_pkg::OP_START, 6'd0, 8'd0);
        send_tick();
        send_cmd(mbk_pkg::OP_STOP, 6'd0, 8'd0);
        send_tick();
    endtask

    // Largest timings first, then the smallest ones with a one-letter text.
    task automatic test_register_extremes();
        wait_drained();
        set_timing(MS_MAX, MS_MAX, MS_MAX, MS_MAX, MS_MAX, 5'h1F, 1'b1);
        send_cmd(mbk_pkg::OP_START, 6'd0, 8'd0);
        send_ticks(3);
        send_cmd(mbk_pkg::OP_STOP, 6'd0, 8'd0);
        wait_drained();
        set_timing(16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 5'h1F, 1'b0);
        send_cmd(mbk_pkg::OP_START, 6'd0, 8'd0);
        send_ticks(14);
        send_cmd(mbk_pkg::OP_STOP, 6'd0, 8'd0);
    endtask

    // Word space, a non-ASCII and a lower-case character, slash and carrier.
    task automatic test_special_chars();
        send_cmd(mbk_pkg::OP_WRITE, 6'd0, mbk_pkg::CHAR_SPACE);
        send_cmd(mbk_pkg::OP_WRITE, 6'd1, 8'hE1);
        send_cmd(mbk_pkg::OP_WRITE, 6'd2, "/");
        send_cmd(mbk_pkg::OP_WRITE, 6'd3, mbk_pkg::CHAR_UNDERSCORE);
        send_cmd(mbk_pkg::OP_WRITE, 6'd4, "a");
        send_cmd(mbk_pkg::OP_WRITE, 6'd5, mbk_pkg::CHAR_NUL);
        send_cmd(mbk_pkg::OP_START, 6'd0, 8'd0);
        send_ticks(60);
        send_cmd(mbk_pkg::OP_STOP, 6'd0, 8'd0);
    endtask

    // Fill the whole store so the walk runs into the last entry.
    task automatic test_store_wrap();
        wait_drained();
        set_timing(16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 5'h1F, 1'b0);
        for (int i = 0; i < mbk_pkg::TEXT_LEN; i++)
            send_cmd(mbk_pkg::OP_WRITE, 6'(i),
                     ($urandom_range(0, 15) == 0) ? pick_text_char()
                                                  : mbk_pkg::CHAR_UNDERSCORE);
        send_cmd(mbk_pkg::OP_START, 6'd0, 8'd0);
        send_ticks(170);
        send_cmd(mbk_pkg::OP_STOP, 6'd0, 8'd0);
    endtask

    // One beacon run: drain, retime, write a short text, start and tick, with
    // an occasional stray command mixed into the ticks.
    task automatic run_beacon_round(input int n_ticks);
        int text_len;
        wait_drained();
        set_timing(($urandom_range(0, 7) == 0) ? 16'($urandom_range(1, 65535))
                                               : 16'($urandom_range(1, 3)),
                   ($urandom_range(0, 9) == 0) ? MS_MAX : 16'($urandom_range(0, 4)),
                   ($urandom_range(0, 9) == 0) ? MS_MAX : 16'($urandom_range(0, 4)),
                   ($urandom_range(0, 9) == 0) ? MS_MAX : 16'($urandom_range(0, 4)),
                   16'($urandom_range(0, 6)),
                   5'($urandom_range(0, 31)) | 5'h01, $urandom_range(0, 3) == 0);
        if ($urandom_range(0, 2) == 0)
            send_cmd(mbk_pkg::OP_STOP, 6'($urandom_range(0, 63)),
                     8'($urandom_range(0, 255)));
        text_len = $urandom_range(1, 8);
        for (int i = 0; i < text_len; i++)
            send_cmd(mbk_pkg::OP_WRITE, 6'(i), pick_text_char());
        send_cmd(mbk_pkg::OP_WRITE, 6'(text_len), mbk_pkg::CHAR_NUL);
        send_cmd(mbk_pkg::OP_START, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
        for (int i = 0; i < n_ticks; i++)
            if ($urandom_range(0, 29) == 0)
                send_cmd(mbk_pkg::opcode_t'($urandom_range(0, 3)),
                         6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
            else
                send_tick();
    endtask

    task automatic test_random_beacon(input int target);
        int stop_at;
        stop_at = cmds_sent + target;
        while (cmds_sent < stop_at)
            run_beacon_round($urandom_range(40, 120));
    endtask

    // Final stretch at full rate: no sender gaps, no status stalls.
    task automatic test_steady_stream();
        wait_drained();
        quiet = 1'b1;
        run_beacon_round(60);
        run_beacon_round(60);
    endtask

    initial
    begin
        rst_n             = 1'b0;
        quiet             = 1'b0;
        mismatches        = 0;
        cmds_sent         = 0;
        cmd_if.valid      = 1'b0;
        cmd_if.opcode     = mbk_pkg::OP_TICK;
        cmd_if.text_index = '0;
        cmd_if.text_char  = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = mbk_pkg::REG_UNIT;
        cfg_if.data       = '0;
        keyer_reset();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_stopped_defaults();
        test_register_extremes();
        test_special_chars();
        test_store_wrap();
        test_random_beacon(120);
        test_steady_stream();

        // Drain, then count any prediction left without a status transaction.
        wait_drained();
        repeat (10) @(posedge clk);
        if (expected_status_q.size() != 0)
        begin
            $display("%0d status transactions never arrived", expected_status_q.size());
            mismatches += expected_status_q.size();
        end
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
